// ===== src/largest_empty_square_finder_top_defines.svh =====
// Assertion macros for the largest empty square finder.
// Used by largest_empty_square_finder_top; expects signals clk and rst_n in scope.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LESF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lesf assertion failed");

// Next-cycle implication, checked outside reset.
`define LESF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lesf assertion failed");

`endif

// ===== src/lesf_pkg.sv =====
// Shared types and constants of the largest empty square finder.
// No dependencies; used by every module of the block but the line buffer.
`default_nettype none

package lesf_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 65536;

    localparam int CFG_W  = 11;
    localparam int SIZE_W = 11;
    localparam int ROW_W  = 16;
    localparam int COL_W  = 10;

    localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

    typedef struct packed {
        logic is_obstacle;
        logic end_of_map;
    } cell_t;

    typedef struct packed {
        logic [SIZE_W-1:0] best_size;
        logic [ROW_W-1:0]  best_row;
        logic [COL_W-1:0]  best_column;
    } result_t;

    // Control flags of the cell that waits in the compute stage.
    typedef struct packed {
        logic is_obstacle;
        logic end_of_map;
        logic row_wrap;
        logic up_valid;
        logic fwd;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ===== src/largest_empty_square_finder_top.sv =====
// Largest empty square finder: one map cell per cycle, back to back, unless stalled as below.
// A result is registered into the output register when the last cell leaves the compute stage.
// Throughput: one cell per cycle, set by one line buffer read and one write per cell.
// A result waiting in the output register stalls input only when another last cell follows.
// Reset (asynchronous, active low) clears counters, fill count and tracker; the line
// buffer needs no clearing pass, so cells are accepted right after reset.
`default_nettype none

`include "largest_empty_square_finder_top_defines.svh"

module largest_empty_square_finder_top #(
    parameter int MAX_COLUMNS = lesf_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lesf_pkg::MAX_ROWS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [lesf_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire lesf_pkg::cell_t            in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output lesf_pkg::result_t               out_data
);

    localparam int CW = $clog2(MAX_COLUMNS);

    logic [lesf_pkg::CFG_W-1:0] map_columns_reg;
    logic                       out_valid_reg, out_valid_next;
    lesf_pkg::result_t          out_data_reg;

    logic                        accept;
    logic                        advance;
    logic                        rd_en;
    logic [CW-1:0]               rd_addr;
    logic [lesf_pkg::SIZE_W-1:0] rd_data;
    logic                        wr_en;
    logic [CW-1:0]               wr_addr;
    logic [lesf_pkg::SIZE_W-1:0] wr_data;
    logic                        s1_valid;
    lesf_pkg::stage_ctl_t        s1_ctl;
    logic [CW-1:0]               s1_col;
    logic [lesf_pkg::ROW_W-1:0]  s1_row;
    lesf_pkg::result_t           result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_columns_reg <= lesf_pkg::CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            map_columns_reg <= cfg_data;
        end
    end

    // The compute stage holds only when a finished map meets a full output register that is not being read.
    assign advance  = s1_valid && (!s1_ctl.end_of_map || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid || advance;
    assign accept   = in_valid && in_ready;

    lesf_scan_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .CW          (CW)
    ) u_scan_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .map_columns (map_columns_reg),
        .accept      (accept),
        .in_cell     (in_data),
        .advance     (advance),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .s1_valid    (s1_valid),
        .s1_ctl      (s1_ctl),
        .s1_col      (s1_col),
        .s1_row      (s1_row)
    );

    lesf_line_buf #(
        .DEPTH (MAX_COLUMNS),
        .AW    (CW),
        .DW    (lesf_pkg::SIZE_W)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lesf_size_unit #(
        .CW (CW)
    ) u_size_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .s1_ctl  (s1_ctl),
        .s1_col  (s1_col),
        .s1_row  (s1_row),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && s1_ctl.end_of_map)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_ctl.end_of_map)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LESF_ASSERT_IMP(a_stall_blocks_input, (s1_valid && !advance), !in_ready)
    `LESF_ASSERT_IMP(a_result_from_last_cell, $rose(out_valid), $past(s1_valid && s1_ctl.end_of_map))
    `LESF_ASSERT_NXT(a_result_captured, (advance && s1_ctl.end_of_map), (out_valid && out_data == $past(result)))
    `LESF_ASSERT_IMP(a_fwd_has_producer, (s1_valid && s1_ctl.fwd), $past(s1_valid))

endmodule

`default_nettype wire

// ===== src/lesf_line_buf.sv =====
// Line buffer holding the square sizes of the previous map row.
// Simple dual-port memory with registered read data; uses no package.
`default_nettype none

module lesf_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/lesf_scan_ctrl.sv =====
// Scan position tracking: column and row counters, line buffer fill count,
// read address and the stage register of the cell being computed. Uses lesf_pkg.
`default_nettype none

module lesf_scan_ctrl #(
    parameter int MAX_COLUMNS = lesf_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lesf_pkg::MAX_ROWS_DEF,
    parameter int CW          = $clog2(MAX_COLUMNS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lesf_pkg::CFG_W-1:0]    map_columns,
    input  wire logic                          accept,
    input  wire lesf_pkg::cell_t               in_cell,
    input  wire logic                          advance,
    output logic                               rd_en,
    output logic [CW-1:0]                      rd_addr,
    output logic                               s1_valid,
    output lesf_pkg::stage_ctl_t               s1_ctl,
    output logic [CW-1:0]                      s1_col,
    output logic [lesf_pkg::ROW_W-1:0]         s1_row
);

    localparam int FW = CW + 1;
    localparam int ROW_LIMIT_INT = (MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1;
    localparam logic [lesf_pkg::ROW_W-1:0] ROW_LIMIT = lesf_pkg::ROW_W'(ROW_LIMIT_INT);

    logic [CW-1:0]              col_reg, col_next;
    logic [lesf_pkg::ROW_W-1:0] row_reg, row_next;
    logic [FW-1:0]              fill_reg, fill_next;
    logic                       s1_valid_reg, s1_valid_next;
    lesf_pkg::stage_ctl_t       s1_ctl_reg, s1_ctl_next;
    logic [CW-1:0]              s1_col_reg;
    logic [lesf_pkg::ROW_W-1:0] s1_row_reg;

    logic [FW-1:0] eff_cols;
    logic [FW-1:0] col_inc;
    logic          wrap;

    always_comb
    begin
        if (map_columns == '0)
        begin
            eff_cols = FW'(1);
        end
        else if (32'(map_columns) > 32'(MAX_COLUMNS))
        begin
            eff_cols = FW'(MAX_COLUMNS);
        end
        else
        begin
            eff_cols = FW'(map_columns);
        end
    end

    assign col_inc = {1'b0, col_reg} + FW'(1);
    assign wrap    = (col_inc >= eff_cols);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        fill_next     = fill_reg;
        s1_valid_next = s1_valid_reg;
        s1_ctl_next   = s1_ctl_reg;

        if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next           = 1'b1;
            s1_ctl_next.is_obstacle = in_cell.is_obstacle;
            s1_ctl_next.end_of_map  = in_cell.end_of_map;
            s1_ctl_next.row_wrap    = wrap;
            // Entries at or beyond the fill count were not written in this map.
            s1_ctl_next.up_valid    = ({1'b0, col_reg} < fill_reg);
            // The previous cell writes the same entry while this one reads it.
            s1_ctl_next.fwd         = s1_valid_reg && (s1_col_reg == col_reg)
                                      && !s1_ctl_reg.end_of_map;

            if (in_cell.end_of_map)
            begin
                col_next  = '0;
                row_next  = '0;
                fill_next = '0;
            end
            else
            begin
                if (wrap)
                begin
                    col_next = '0;
                    if (row_reg < ROW_LIMIT)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_inc[CW-1:0];
                end
                if (col_inc > fill_reg)
                begin
                    fill_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
            s1_ctl_reg   <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    assign rd_en    = accept;
    assign rd_addr  = col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_col   = s1_col_reg;
    assign s1_row   = s1_row_reg;

endmodule

`default_nettype wire

// ===== src/lesf_size_unit.sv =====
// Square size computation and largest-square tracking for the cell in the
// compute stage; produces the line buffer write-back. Uses lesf_pkg.
`default_nettype none

module lesf_size_unit #(
    parameter int CW = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire lesf_pkg::stage_ctl_t        s1_ctl,
    input  wire logic [CW-1:0]               s1_col,
    input  wire logic [lesf_pkg::ROW_W-1:0]  s1_row,
    input  wire logic [lesf_pkg::SIZE_W-1:0] rd_data,
    output logic                             wr_en,
    output logic [CW-1:0]                    wr_addr,
    output logic [lesf_pkg::SIZE_W-1:0]      wr_data,
    output lesf_pkg::result_t                result
);

    logic [lesf_pkg::SIZE_W-1:0] left_reg, left_next;
    logic [lesf_pkg::SIZE_W-1:0] diag_reg, diag_next;
    logic [lesf_pkg::SIZE_W-1:0] lg_size_reg, lg_size_next;
    logic [lesf_pkg::ROW_W-1:0]  lg_row_reg, lg_row_next;
    logic [CW-1:0]               lg_col_reg, lg_col_next;
    logic [lesf_pkg::SIZE_W-1:0] last_size_reg;

    logic [lesf_pkg::SIZE_W-1:0] up;
    logic [lesf_pkg::SIZE_W-1:0] min_lu;
    logic [lesf_pkg::SIZE_W-1:0] min_all;
    logic [lesf_pkg::SIZE_W-1:0] size;
    logic [lesf_pkg::SIZE_W-1:0] upd_size;
    logic [lesf_pkg::ROW_W-1:0]  upd_row;
    logic [CW-1:0]               upd_col;
    logic                        restart;

    always_comb
    begin
        if (!s1_ctl.up_valid)
        begin
            up = '0;
        end
        else if (s1_ctl.fwd)
        begin
            up = last_size_reg;
        end
        else
        begin
            up = rd_data;
        end
    end

    assign min_lu  = (left_reg < up) ? left_reg : up;
    assign min_all = (min_lu < diag_reg) ? min_lu : diag_reg;

    always_comb
    begin
        if (s1_ctl.is_obstacle)
        begin
            size = '0;
        end
        else if (min_all == lesf_pkg::SIZE_SAT)
        begin
            size = lesf_pkg::SIZE_SAT;
        end
        else
        begin
            size = min_all + 1'b1;
        end
    end

    // Only a strictly larger square replaces the kept one.
    always_comb
    begin
        if (size > lg_size_reg)
        begin
            upd_size = size;
            upd_row  = s1_row;
            upd_col  = s1_col;
        end
        else
        begin
            upd_size = lg_size_reg;
            upd_row  = lg_row_reg;
            upd_col  = lg_col_reg;
        end
    end

    assign restart = s1_ctl.end_of_map || s1_ctl.row_wrap;

    always_comb
    begin
        left_next    = left_reg;
        diag_next    = diag_reg;
        lg_size_next = lg_size_reg;
        lg_row_next  = lg_row_reg;
        lg_col_next  = lg_col_reg;
        if (advance)
        begin
            left_next = restart ? '0 : size;
            diag_next = restart ? '0 : up;
            if (s1_ctl.end_of_map)
            begin
                lg_size_next = '0;
                lg_row_next  = '0;
                lg_col_next  = '0;
            end
            else
            begin
                lg_size_next = upd_size;
                lg_row_next  = upd_row;
                lg_col_next  = upd_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg    <= '0;
            diag_reg    <= '0;
            lg_size_reg <= '0;
            lg_row_reg  <= '0;
            lg_col_reg  <= '0;
        end
        else
        begin
            left_reg    <= left_next;
            diag_reg    <= diag_next;
            lg_size_reg <= lg_size_next;
            lg_row_reg  <= lg_row_next;
            lg_col_reg  <= lg_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last_size_reg <= size;
        end
    end

    assign wr_en   = advance;
    assign wr_addr = s1_col;
    assign wr_data = size;

    assign result.best_size   = upd_size;
    assign result.best_row    = upd_row;
    assign result.best_column = lesf_pkg::COL_W'(upd_col);

endmodule

`default_nettype wire
